// ===== design/u2d_pkg.sv =====
package u2d_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned PARTIAL_W = 12;
  localparam int unsigned PEND_W    = 3;
  localparam int unsigned CONT_W    = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [PEND_W-1:0]  PEND_TWO   = 3'd1;
  localparam logic [PEND_W-1:0]  PEND_THREE = 3'd2;
  localparam logic [PEND_W-1:0]  PEND_SKIP3 = 3'd3;
  localparam logic [PEND_W-1:0]  PEND_SKIP4 = 3'd4;

  typedef struct packed {
    logic               emit;
    logic [UNIT_W-1:0]  code_unit;
    logic               end_of_string;
    logic [COUNT_W-1:0] unit_count;
  } result_t;

endpackage

// ===== design/u2d_decode.sv =====
module u2d_decode
  import u2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              advance,
  output result_t           result
);

  logic [PEND_W-1:0]    pending_r,  pending_nxt;
  logic                 skipping_r, skipping_nxt;
  logic [PARTIAL_W-1:0] partial_r,  partial_nxt;
  logic [COUNT_W-1:0]   count_r,    count_nxt;

  logic [UNIT_W-1:0]  assembled;
  logic [COUNT_W-1:0] count_inc;
  logic [PEND_W-1:0]  pending_dec;

  assign assembled   = {partial_r[UNIT_W-CONT_W-1:0], data_byte[CONT_W-1:0]};
  assign count_inc   = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign pending_dec = pending_r - 1'b1;

  always_comb begin
    pending_nxt  = pending_r;
    skipping_nxt = skipping_r;
    partial_nxt  = partial_r;
    count_nxt    = count_r;
    result       = '0;

    if (pending_r != '0) begin
      pending_nxt = pending_dec;
      if (skipping_r) begin
        if (pending_dec == '0) begin
          skipping_nxt = 1'b0;
        end
      end else if (pending_dec == '0) begin
        partial_nxt       = '0;
        count_nxt         = count_inc;
        result.emit       = 1'b1;
        result.code_unit  = assembled;
        result.unit_count = count_inc;
      end else begin
        partial_nxt = assembled[PARTIAL_W-1:0];
      end
    end else if (data_byte == '0) begin
      count_nxt            = '0;
      result.emit          = 1'b1;
      result.end_of_string = 1'b1;
      result.unit_count    = count_r;
    end else if (data_byte[7:6] == 2'b11) begin
      if (!data_byte[5]) begin
        partial_nxt  = {{(PARTIAL_W-5){1'b0}}, data_byte[4:0]};
        pending_nxt  = PEND_TWO;
        skipping_nxt = 1'b0;
      end else if (!data_byte[4]) begin
        partial_nxt  = {{(PARTIAL_W-4){1'b0}}, data_byte[3:0]};
        pending_nxt  = PEND_THREE;
        skipping_nxt = 1'b0;
      end else begin
        partial_nxt  = '0;
        pending_nxt  = data_byte[3] ? PEND_SKIP4 : PEND_SKIP3;
        skipping_nxt = 1'b1;
      end
    end else begin
      count_nxt         = count_inc;
      result.emit       = 1'b1;
      result.code_unit  = {{(UNIT_W-BYTE_W){1'b0}}, data_byte};
      result.unit_count = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      skipping_r <= 1'b0;
      partial_r  <= '0;
      count_r    <= '0;
    end else if (advance) begin
      pending_r  <= pending_nxt;
      skipping_r <= skipping_nxt;
      partial_r  <= partial_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

// ===== design/utf8_to_ucs2_decoder.sv =====
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   in_data_byte[7:0]
// out_      result     out_valid/out_stall out_code_unit[15:0], out_end_of_string,
//                                          out_unit_count[15:0]
//
// One byte per cycle sustained while out_stall is low; a byte is held in
// the input register and its unit, if any, is registered into the output register.
// Result valid comes from the output register; a result can be accepted while out_valid is high.
// Synchronous active-low reset clears all control state and the unit count.
// A byte with no unit leaves the input register even while out_stall holds;
// a byte with a unit waits only while the output register is full and stalled.
module utf8_to_ucs2_decoder
  import u2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [UNIT_W-1:0]  out_code_unit,
  output logic               out_end_of_string,
  output logic [COUNT_W-1:0] out_unit_count
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           result;
  logic              out_free;
  logic              advance;
  logic              in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && (!result.emit || out_free);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  u2d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_byte_r),
    .advance   (advance),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && result.emit) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_unit     = out_r.code_unit;
  assign out_end_of_string = out_r.end_of_string;
  assign out_unit_count    = out_r.unit_count;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import u2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [BYTE_W-1:0] data;
    bit                steady;
    bit                drain_first;
  } byte_item_t;

  typedef struct {
    logic [UNIT_W-1:0]  code_unit;
    logic               end_of_string;
    logic [COUNT_W-1:0] unit_count;
    bit                 steady;
  } unit_rec_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [UNIT_W-1:0]  out_code_unit;
  logic               out_end_of_string;
  logic [COUNT_W-1:0] out_unit_count;

  byte_item_t pending_bytes[$];
  unit_rec_t  decoded_units[$];
  byte_item_t cur_item;
  unit_rec_t  head_unit;

  logic [PEND_W-1:0]    utf_pending = '0;
  logic                 utf_skip = 1'b0;
  logic [PARTIAL_W-1:0] utf_partial = '0;
  logic [COUNT_W-1:0]   utf_count = '0;

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  rx_steady = 1'b0;

  utf8_to_ucs2_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_unit     (out_code_unit),
    .out_end_of_string (out_end_of_string),
    .out_unit_count    (out_unit_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic emit_unit(input logic [UNIT_W-1:0] unit, input bit steady);
    if (utf_count != COUNT_MAX) begin
      utf_count = utf_count + 1'b1;
    end
    decoded_units.push_back('{unit, 1'b0, utf_count, steady});
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input bit steady);
    logic [UNIT_W-1:0] joined;
    joined = {utf_partial[9:0], b[CONT_W-1:0]};
    if (utf_pending != '0) begin
      utf_pending = utf_pending - 1'b1;
      if (utf_skip) begin
        if (utf_pending == '0) utf_skip = 1'b0;
      end else if (utf_pending == '0) begin
        utf_partial = '0;
        emit_unit(joined, steady);
      end else begin
        utf_partial = joined[PARTIAL_W-1:0];
      end
    end else if (b == 8'h00) begin
      decoded_units.push_back('{16'h0000, 1'b1, utf_count, steady});
      utf_count = '0;
    end else if (b[7:6] == 2'b11) begin
      if (!b[5]) begin
        utf_partial = {7'b0, b[4:0]};
        utf_pending = PEND_TWO;
        utf_skip = 1'b0;
      end else if (!b[4]) begin
        utf_partial = {8'b0, b[3:0]};
        utf_pending = PEND_THREE;
        utf_skip = 1'b0;
      end else begin
        utf_partial = '0;
        utf_pending = b[3] ? PEND_SKIP4 : PEND_SKIP3;
        utf_skip = 1'b1;
      end
    end else begin
      emit_unit({8'h00, b}, steady);
    end
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] b, input bit steady = 1'b0,
                          input bit drain_first = 1'b0);
    pending_bytes.push_back('{b, steady, drain_first});
  endtask

  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic add_random_char();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind <= 5) begin
      add_byte(8'($urandom_range(1, 127)));
    end else if (kind <= 8) begin
      add_byte({3'b110, 5'($urandom)});
      add_byte(cont_byte());
    end else if (kind <= 11) begin
      add_byte({4'b1110, 4'($urandom)});
      add_byte(cont_byte());
      add_byte(cont_byte());
    end else if (kind == 12) begin
      add_byte({5'b11110, 3'($urandom)});
      repeat (3) add_byte(8'($urandom_range(0, 255)));
    end else if (kind == 13) begin
      add_byte({5'b11111, 3'($urandom)});
      repeat (4) add_byte(8'($urandom_range(0, 255)));
    end else if (kind == 16) begin
      add_byte({2'b10, 6'($urandom)});
    end else if (kind == 17) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (kind == 18) begin
      add_byte(8'($urandom_range(8'hC0, 8'hEF)));
      repeat (2) add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_byte(8'h00);
    end
  endtask

  // sender: hold a stalled request, draw the gap before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, cur_item.steady);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain_first && decoded_units.size() != 0)) begin
          cur_item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= cur_item.data;
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap = (cur_item.steady || tx_burst) ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each unit against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        rx_steady = 1'b0;
        if (decoded_units.size() == 0) begin
          report_mismatch($sformatf("unit %h arrived with nothing pending", out_code_unit));
        end else begin
          head_unit = decoded_units.pop_front();
          rx_steady = head_unit.steady;
          if (out_code_unit !== head_unit.code_unit)
            report_mismatch($sformatf("code_unit got %h want %h",
                                      out_code_unit, head_unit.code_unit));
          if (out_end_of_string !== head_unit.end_of_string)
            report_mismatch($sformatf("end_of_string got %b want %b",
                                      out_end_of_string, head_unit.end_of_string));
          if (out_unit_count !== head_unit.unit_count)
            report_mismatch($sformatf("unit_count got %0d want %0d",
                                      out_unit_count, head_unit.unit_count));
        end
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = (rx_steady || rx_burst) ? 0 : $urandom_range(0, 10);
        if (results_seen == 15) rx_wait = 150;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  initial begin
    add_byte(8'h00);
    add_byte(8'h41);
    add_byte(8'h80);
    add_byte(8'hBF);
    add_byte(8'hC0);
    add_byte(8'h00);
    add_byte(8'hDF);
    add_byte(8'hFF);
    add_byte(8'hE0);
    add_byte(8'h80);
    add_byte(8'h80);
    add_byte(8'hEF);
    add_byte(8'hBF);
    add_byte(8'hBF);
    add_byte(8'hF0);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h41);
    add_byte(8'hFF);
    repeat (4) add_byte(8'h00);
    add_byte(8'h01);
    add_byte(8'h00);

    // steady run: the receiver holds off mid-string so the block fills up
    repeat (40) add_byte(8'($urandom_range(1, 127)), 1'b1);
    add_byte(8'h00, 1'b1);

    add_byte(8'h7F, 1'b0, 1'b1);
    while (pending_bytes.size() < 949) add_random_char();
    add_byte(8'h00);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid || decoded_units.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
design/u2d_pkg.sv
design/u2d_decode.sv
design/utf8_to_ucs2_decoder.sv
tb/tb_top.sv
